### src/dccf_pkg.sv
// Shared types and constants of the draw call frustum cull filter.
// Depends on nothing; every other file refers to it by scoped names.
package dccf_pkg;

    localparam int unsigned FIELD_W      = 32;
    localparam int unsigned HANDLE_W     = 32;
    localparam int unsigned PLANE_COUNT  = 6;
    localparam int unsigned MATRIX_DEPTH = 16;
    localparam int unsigned FIFO_DEPTH   = 4;
    localparam logic signed [FIELD_W-1:0] MIN_ELEMENTS   = 32'sd2;
    localparam logic        [HANDLE_W-1:0] INVALID_HANDLE = 32'hFFFF_FFFF;

    // Class of a word as decided by the front end
    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_DROP = 2'd1,
        KIND_DRAW = 2'd2
    } kind_t;

    // Result code of one word
    typedef enum logic [1:0] {
        OUT_DRAWN   = 2'd0,
        OUT_DROPPED = 2'd1,
        OUT_CULLED  = 2'd2,
        OUT_STORED  = 2'd3
    } outcome_t;

    // Classification carried with each queued word
    typedef struct packed {
        kind_t kind;
        logic  box_ok;
    } item_ctl_t;

    localparam int unsigned CTL_W = $bits(item_ctl_t);

    // Queue status seen by the front and back ends
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

### src/dccf_front.sv
// Front end: classifies each incoming word and packs it for the queue.
// Depends on dccf_pkg.
module dccf_front #(
    parameter int COORD_WIDTH = 32,
    parameter int QW          = 3 + 7 * 32 + 64
) (
    input  logic                           cmd,
    input  logic        [31:0]             elem_value,
    input  logic signed [31:0]             vertex_count,
    input  logic signed [31:0]             index_count,
    input  logic        [31:0]             program_id,
    input  logic        [31:0]             texture_id,
    input  logic        [31:0]             box_min_x,
    input  logic        [31:0]             box_min_y,
    input  logic        [31:0]             box_min_z,
    input  logic        [31:0]             box_max_x,
    input  logic        [31:0]             box_max_y,
    input  logic        [31:0]             box_max_z,
    output logic        [QW-1:0]           word
);

    localparam int CW = COORD_WIDTH;

    // Take the low CW bits of a field, zero filled when CW is wider
    function automatic logic [CW-1:0] to_coord(input logic [31:0] f);
        logic [CW+31:0] t;
        t = {{CW{1'b0}}, f};
        return t[CW-1:0];
    endfunction

    logic [CW-1:0] elem_c;
    logic [CW-1:0] bmin_x, bmin_y, bmin_z, bmax_x, bmax_y, bmax_z;
    dccf_pkg::item_ctl_t ctl;

    // Convert fields to coordinate width
    always_comb
    begin
        elem_c = to_coord(elem_value);
        bmin_x = to_coord(box_min_x);
        bmin_y = to_coord(box_min_y);
        bmin_z = to_coord(box_min_z);
        bmax_x = to_coord(box_max_x);
        bmax_y = to_coord(box_max_y);
        bmax_z = to_coord(box_max_z);
    end

    // Classify: load, drop on too few elements, or draw
    always_comb
    begin
        ctl.box_ok = $signed(bmax_x) >= $signed(bmin_x);
        if (!cmd)
        begin
            ctl.kind = dccf_pkg::KIND_LOAD;
        end
        else if (vertex_count < dccf_pkg::MIN_ELEMENTS
                 || index_count < dccf_pkg::MIN_ELEMENTS)
        begin
            ctl.kind = dccf_pkg::KIND_DROP;
        end
        else
        begin
            ctl.kind = dccf_pkg::KIND_DRAW;
        end
    end

    // Pack the word for the queue
    assign word = {ctl, elem_c, bmin_x, bmin_y, bmin_z, bmax_x, bmax_y, bmax_z,
                   program_id, texture_id};

endmodule

### src/dccf_fifo.sv
// Short queue between the front and back ends, register based.
// Depends on dccf_pkg.
module dccf_fifo #(
    parameter int W = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [W-1:0]          push_word,
    input  logic                  pop,
    output logic [W-1:0]          pop_word,
    output dccf_pkg::fifo_status_t status
);

    localparam int DEPTH = dccf_pkg::FIFO_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg, count_next;

    // Store pushed words
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

    // Advance pointers and count
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign pop_word     = mem_reg[rd_ptr_reg];
    assign status.full  = count_reg == (AW+1)'(DEPTH);
    assign status.empty = count_reg == '0;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (AW+1)'(DEPTH))
        else $error("queue count above depth");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        status.full && !pop |-> !push)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        status.empty |-> !pop)
        else $error("pop from empty queue");
`endif

endmodule

### src/dccf_back.sv
// Back end: applies matrix loads, runs the six-plane test and tracks bindings.
// Two stages: products, then distance sums, decision and output register.
// Depends on dccf_pkg.
module dccf_back #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    parameter int QW          = 3 + 7 * 32 + 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  dccf_pkg::fifo_status_t  status,
    input  logic [QW-1:0]           pop_word,
    output logic                    pop,
    input  logic                    out_ready,
    output logic                    out_valid,
    output logic [1:0]              outcome,
    output logic                    flush_batch,
    output logic                    program_changed,
    output logic                    texture_changed
);

    localparam int CW = COORD_WIDTH;
    localparam int PW = 2 * CW + 1;
    localparam int SW = 2 * CW + FRAC_BITS + 4;
    localparam int NP = dccf_pkg::PLANE_COUNT;
    localparam int MD = dccf_pkg::MATRIX_DEPTH;
    localparam int HW = dccf_pkg::HANDLE_W;

    // Unpacked queue word
    dccf_pkg::item_ctl_t      q_ctl;
    logic signed [CW-1:0]     q_elem;
    logic signed [CW-1:0]     q_bmin [3];
    logic signed [CW-1:0]     q_bmax [3];
    logic [HW-1:0]            q_prog, q_tex;

    assign {q_ctl, q_elem, q_bmin[0], q_bmin[1], q_bmin[2],
            q_bmax[0], q_bmax[1], q_bmax[2], q_prog, q_tex} = pop_word;

    // Matrix and culling state
    logic signed [CW-1:0] mat_reg [MD];
    logic [3:0]           ptr_reg;
    logic                 culling_on_reg;

    // Stage one
    logic                 v1_reg;
    dccf_pkg::kind_t      kind1_reg;
    logic                 cull_en1_reg;
    logic [HW-1:0]        prog1_reg, tex1_reg;
    logic signed [PW-1:0] prod_reg [NP][3];
    logic signed [CW:0]   d_reg [NP];

    // Stage two and bindings
    logic                 v2_reg;
    dccf_pkg::outcome_t   outcome_reg, outcome_next;
    logic                 flush_reg, pc_reg, tc_reg;
    logic                 flush_next, pc_next, tc_next;
    logic [HW-1:0]        bound_prog_reg, bound_tex_reg;

    logic en2, en1;
    logic signed [CW:0]   coef_c [NP][4];
    logic signed [PW-1:0] prod_c [NP][3];
    logic signed [SW-1:0] dist_c [NP];
    logic [NP-1:0]        neg_c;
    logic                 culled_c;

    // Handshake between stages
    assign en2 = !v2_reg || out_ready;
    assign en1 = !v1_reg || en2;
    assign pop = en1 && !status.empty;

    // Form plane coefficients and box products from the current matrix
    always_comb
    begin
        for (int p = 0; p < NP; p++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                if ((p % 2) == 0)
                begin
                    coef_c[p][k] = (CW+1)'(mat_reg[4*k+3]) + (CW+1)'(mat_reg[4*k+p/2]);
                end
                else
                begin
                    coef_c[p][k] = (CW+1)'(mat_reg[4*k+3]) - (CW+1)'(mat_reg[4*k+p/2]);
                end
            end
            for (int k = 0; k < 3; k++)
            begin
                if (coef_c[p][k] > 0)
                begin
                    prod_c[p][k] = PW'(coef_c[p][k]) * PW'(q_bmax[k]);
                end
                else
                begin
                    prod_c[p][k] = PW'(coef_c[p][k]) * PW'(q_bmin[k]);
                end
            end
        end
    end

    // Apply matrix loads in queue order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MD; i++)
            begin
                mat_reg[i] <= '0;
            end
            ptr_reg        <= '0;
            culling_on_reg <= 1'b0;
        end
        else if (pop && q_ctl.kind == dccf_pkg::KIND_LOAD)
        begin
            mat_reg[ptr_reg] <= q_elem;
            ptr_reg          <= ptr_reg + 1'b1;
            if (ptr_reg == 4'hF)
            begin
                culling_on_reg <= 1'b1;
            end
        end
    end

    // Stage one control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en1)
        begin
            v1_reg <= !status.empty;
        end
    end

    // Stage one payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind1_reg    <= q_ctl.kind;
            cull_en1_reg <= culling_on_reg && q_ctl.box_ok;
            prog1_reg    <= q_prog;
            tex1_reg     <= q_tex;
            for (int p = 0; p < NP; p++)
            begin
                d_reg[p] <= coef_c[p][3];
                for (int k = 0; k < 3; k++)
                begin
                    prod_reg[p][k] <= prod_c[p][k];
                end
            end
        end
    end

    // Sum plane distances and test the signs
    always_comb
    begin
        for (int p = 0; p < NP; p++)
        begin
            dist_c[p] = (SW'(d_reg[p]) <<< FRAC_BITS) + SW'(prod_reg[p][0])
                        + SW'(prod_reg[p][1]) + SW'(prod_reg[p][2]);
            neg_c[p]  = dist_c[p][SW-1];
        end
        culled_c = cull_en1_reg && (|neg_c);
    end

    // Decide the outcome and the binding flags
    always_comb
    begin
        outcome_next = dccf_pkg::OUT_STORED;
        pc_next      = 1'b0;
        tc_next      = 1'b0;
        case (kind1_reg)
            dccf_pkg::KIND_LOAD: outcome_next = dccf_pkg::OUT_STORED;
            dccf_pkg::KIND_DROP: outcome_next = dccf_pkg::OUT_DROPPED;
            dccf_pkg::KIND_DRAW:
            begin
                if (culled_c)
                begin
                    outcome_next = dccf_pkg::OUT_CULLED;
                end
                else
                begin
                    outcome_next = dccf_pkg::OUT_DRAWN;
                    pc_next      = prog1_reg != bound_prog_reg;
                    tc_next      = tex1_reg != bound_tex_reg;
                end
            end
            default: outcome_next = dccf_pkg::OUT_STORED;
        endcase
        flush_next = pc_next || tc_next;
    end

    // Stage two control and bindings
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg         <= 1'b0;
            bound_prog_reg <= dccf_pkg::INVALID_HANDLE;
            bound_tex_reg  <= dccf_pkg::INVALID_HANDLE;
        end
        else if (en2)
        begin
            v2_reg <= v1_reg;
            if (v1_reg && outcome_next == dccf_pkg::OUT_DRAWN)
            begin
                bound_prog_reg <= prog1_reg;
                bound_tex_reg  <= tex1_reg;
            end
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            outcome_reg <= outcome_next;
            flush_reg   <= flush_next;
            pc_reg      <= pc_next;
            tc_reg      <= tc_next;
        end
    end

    assign out_valid       = v2_reg;
    assign outcome         = outcome_reg;
    assign flush_batch     = flush_reg;
    assign program_changed = pc_reg;
    assign texture_changed = tc_reg;

`ifndef SYNTHESIS
    a_cull_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        culling_on_reg |=> culling_on_reg)
        else $error("culling turned off");
    a_cull_enable: assert property (@(posedge clk) disable iff (!rst_n)
        pop && q_ctl.kind == dccf_pkg::KIND_LOAD && ptr_reg == 4'hF |=> culling_on_reg)
        else $error("last element did not enable culling");
    a_flags_drawn: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && outcome_reg != dccf_pkg::OUT_DRAWN |-> !flush_reg && !pc_reg && !tc_reg)
        else $error("flags set on non-drawn word");
    a_flush_or: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> flush_reg == (pc_reg || tc_reg))
        else $error("flush does not match change flags");
`endif

endmodule

### src/draw_call_frustum_cull_filter.sv
// Path from input accept to result valid: queue, stage one, output register.
// Throughput: one word per cycle unless out_ready stalls; six planes are tested
// in parallel lanes with one multiply stage and one summing stage after a
// four-entry queue.
// Reset: matrix cleared to zero, write pointer zero, culling off, program and
// texture bindings set to the invalid handle, queue and pipeline emptied.
module draw_call_frustum_cull_filter #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cmd,
    input  logic        [31:0] elem_value,
    input  logic signed [31:0] vertex_count,
    input  logic signed [31:0] index_count,
    input  logic        [31:0] program_id,
    input  logic        [31:0] texture_id,
    input  logic        [31:0] box_min_x,
    input  logic        [31:0] box_min_y,
    input  logic        [31:0] box_min_z,
    input  logic        [31:0] box_max_x,
    input  logic        [31:0] box_max_y,
    input  logic        [31:0] box_max_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic        [1:0]  outcome,
    output logic               flush_batch,
    output logic               program_changed,
    output logic               texture_changed
);

    localparam int QW = dccf_pkg::CTL_W + 7 * COORD_WIDTH + 2 * dccf_pkg::HANDLE_W;

    logic [QW-1:0]          push_word, pop_word;
    logic                   push, pop;
    dccf_pkg::fifo_status_t status;

    // Accept a word whenever the queue has room
    assign in_ready = !status.full;
    assign push     = in_valid && in_ready;

    dccf_front #(
        .COORD_WIDTH(COORD_WIDTH),
        .QW(QW)
    ) u_front (
        .cmd(cmd),
        .elem_value(elem_value),
        .vertex_count(vertex_count),
        .index_count(index_count),
        .program_id(program_id),
        .texture_id(texture_id),
        .box_min_x(box_min_x),
        .box_min_y(box_min_y),
        .box_min_z(box_min_z),
        .box_max_x(box_max_x),
        .box_max_y(box_max_y),
        .box_max_z(box_max_z),
        .word(push_word)
    );

    dccf_fifo #(
        .W(QW)
    ) u_fifo (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .push_word(push_word),
        .pop(pop),
        .pop_word(pop_word),
        .status(status)
    );

    dccf_back #(
        .COORD_WIDTH(COORD_WIDTH),
        .FRAC_BITS(FRAC_BITS),
        .QW(QW)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .status(status),
        .pop_word(pop_word),
        .pop(pop),
        .out_ready(out_ready),
        .out_valid(out_valid),
        .outcome(outcome),
        .flush_batch(flush_batch),
        .program_changed(program_changed),
        .texture_changed(texture_changed)
    );

endmodule

### verif/tb_draw_call_frustum_cull_filter.sv
// Testbench for the draw call frustum cull filter: drives load and draw words,
// predicts each result with a local plane-test model held in a scoreboard class.
// Depends on dccf_pkg and draw_call_frustum_cull_filter.
module tb_draw_call_frustum_cull_filter;

    // Expected result of one word
    typedef struct {
        dccf_pkg::outcome_t oc;
        logic               flush;
        logic               pchg;
        logic               tchg;
    } cull_result_t;

    // Error count, bumped by report_mismatch
    int unsigned errors = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // Frustum cull predictor plus queue of pending results
    class cull_scoreboard;
        logic signed [31:0] vp[16];
        logic [3:0]         wptr;
        bit                 cull_en;
        logic [31:0]        cur_prog;
        logic [31:0]        cur_tex;
        cull_result_t       pending[$];
        int unsigned        n_drawn, n_dropped, n_culled, n_stored;

        function new();
            foreach (vp[i]) vp[i] = '0;
            wptr     = '0;
            cull_en  = 0;
            cur_prog = dccf_pkg::INVALID_HANDLE;
            cur_tex  = dccf_pkg::INVALID_HANDLE;
        endfunction

        // Farthest corner behind any of the six planes
        function bit outside(logic signed [31:0] bmin[3], logic signed [31:0] bmax[3]);
            logic signed [33:0]  coef[4];
            logic signed [127:0] plane_dist;
            for (int p = 0; p < dccf_pkg::PLANE_COUNT; p++)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    if (p % 2 == 0)
                        coef[k] = 34'(vp[4*k+3]) + 34'(vp[4*k+p/2]);
                    else
                        coef[k] = 34'(vp[4*k+3]) - 34'(vp[4*k+p/2]);
                end
                plane_dist = 128'(coef[3]) <<< 16;
                for (int k = 0; k < 3; k++)
                    plane_dist += 128'(coef[k]) * 128'(coef[k] > 0 ? bmax[k] : bmin[k]);
                if (plane_dist < 0)
                    return 1;
            end
            return 0;
        endfunction

        // Note one accepted word and queue its expected result
        function void note_word(logic c, logic [31:0] ev, logic signed [31:0] vc,
                                logic signed [31:0] ic, logic [31:0] pid,
                                logic [31:0] tid, logic [31:0] bmin[3],
                                logic [31:0] bmax[3]);
            cull_result_t       r;
            logic signed [31:0] smin[3], smax[3];
            for (int k = 0; k < 3; k++)
            begin
                smin[k] = $signed(bmin[k]);
                smax[k] = $signed(bmax[k]);
            end
            r = '{dccf_pkg::OUT_DRAWN, 0, 0, 0};
            if (!c)
            begin
                vp[wptr] = ev;
                if (wptr == 4'd15)
                    cull_en = 1;
                wptr++;
                r.oc = dccf_pkg::OUT_STORED;
                n_stored++;
            end
            else if (vc < dccf_pkg::MIN_ELEMENTS || ic < dccf_pkg::MIN_ELEMENTS)
            begin
                r.oc = dccf_pkg::OUT_DROPPED;
                n_dropped++;
            end
            else if (cull_en && smax[0] >= smin[0] && outside(smin, smax))
            begin
                r.oc = dccf_pkg::OUT_CULLED;
                n_culled++;
            end
            else
            begin
                r.pchg  = pid != cur_prog;
                r.tchg  = tid != cur_tex;
                r.flush = r.pchg | r.tchg;
                cur_prog = pid;
                cur_tex  = tid;
                n_drawn++;
            end
            pending.push_back(r);
        endfunction

        // Compare one result with the oldest expectation
        task check_result(logic [1:0] oc, logic fl, logic pc, logic tc);
            cull_result_t e;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected result outcome", oc, -1);
                return;
            end
            e = pending.pop_front();
            if (oc !== e.oc)    report_mismatch("outcome", oc, e.oc);
            if (fl !== e.flush) report_mismatch("flush_batch", fl, e.flush);
            if (pc !== e.pchg)  report_mismatch("program_changed", pc, e.pchg);
            if (tc !== e.tchg)  report_mismatch("texture_changed", tc, e.tchg);
        endtask
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0, out_ready = 0;
    wire         in_ready, out_valid;
    logic        cmd = 0;
    logic [31:0] elem_value = 0, program_id = 0, texture_id = 0;
    logic signed [31:0] vertex_count = 0, index_count = 0;
    logic [31:0] box_min_x = 0, box_min_y = 0, box_min_z = 0;
    logic [31:0] box_max_x = 0, box_max_y = 0, box_max_z = 0;
    wire  [1:0]  outcome;
    wire         flush_batch, program_changed, texture_changed;

    cull_scoreboard sb = new();
    bit   calm = 0;       // no idling in the last part of the run

    draw_call_frustum_cull_filter DUT (.*);

    always #5 clk = ~clk;

    // Check results and stall the receiver in bursts
    initial
    begin : sink
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_result(outcome, flush_batch, program_changed, texture_changed);
            if (stall > 0)
                stall--;
            else if (!calm && $urandom_range(0, 9) == 0)
                stall = $urandom_range(1, 15);
            out_ready <= (stall == 0);
        end
    end

    // Random 32-bit value biased toward edges
    function automatic logic [31:0] rnd_edge();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0;
            default: return $urandom();
        endcase
    endfunction

    // Present one word and hold it until accepted, with an optional gap first
    task automatic send_word(logic c, logic [31:0] ev, logic [31:0] vc, logic [31:0] ic,
                             logic [31:0] pid, logic [31:0] tid,
                             logic [31:0] mn[3], logic [31:0] mx[3]);
        int gap;
        gap = (!calm && $urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        cmd <= c; elem_value <= ev; vertex_count <= vc; index_count <= ic;
        program_id <= pid; texture_id <= tid;
        box_min_x <= mn[0]; box_min_y <= mn[1]; box_min_z <= mn[2];
        box_max_x <= mx[0]; box_max_y <= mx[1]; box_max_z <= mx[2];
        in_valid <= 1;
        do @(posedge clk); while (!in_ready);
        sb.note_word(c, ev, vc, ic, pid, tid, mn, mx);
    endtask

    // Matrix element load
    task automatic load_elem(logic [31:0] v);
        logic [31:0] z[3];
        z = '{0, 0, 0};
        send_word(0, v, $urandom(), $urandom(), $urandom(), $urandom(), z, z);
    endtask

    // Draw request with small handle set so bindings repeat
    task automatic draw_rand(bit wild);
        logic [31:0] mn[3], mx[3], c;
        for (int k = 0; k < 3; k++)
        begin
            if (wild)
            begin
                mn[k] = rnd_edge();
                mx[k] = rnd_edge();
            end
            else
            begin
                c = $urandom_range(0, 40 << 16) - (20 << 16);
                mn[k] = c - $urandom_range(0, 4 << 16);
                mx[k] = c + $urandom_range(0, 4 << 16);
            end
        end
        if ($urandom_range(0, 15) == 0)
            mx[0] = mn[0] - 1;
        send_word(1, $urandom(),
                  $urandom_range(0, 9) == 0 ? rnd_edge() : $urandom_range(0, 100),
                  $urandom_range(0, 9) == 0 ? rnd_edge() : $urandom_range(0, 100),
                  $urandom_range(0, 3) == 0 ? rnd_edge() : $urandom_range(0, 3),
                  $urandom_range(0, 3) == 0 ? rnd_edge() : $urandom_range(0, 3),
                  mn, mx);
    endtask

    // Load a perspective-like matrix with random jitter
    task automatic load_matrix(bit wild);
        logic [31:0] v;
        for (int i = 0; i < 16; i++)
        begin
            if (wild)
                v = rnd_edge();
            else
            begin
                v = $urandom_range(0, 1 << 17) - (1 << 16);
                if (i == 0 || i == 5 || i == 10) v = 32'h0001_0000 + (v >>> 3);
                if (i == 11) v = 32'hFFFF_0000;
            end
            load_elem(v);
        end
    endtask

    // Drop valid and wait until every expected result has come
    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 0;
        while (sb.pending.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
    endtask

    initial
    begin : stim
        logic [31:0] mn[3], mx[3];
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: draws before culling, count edges, invalid handle, inverted box
        mn = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        mx = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        send_word(1, 0, 2, 2, dccf_pkg::INVALID_HANDLE, dccf_pkg::INVALID_HANDLE, mn, mx);
        send_word(1, 0, 2, 2, 5, dccf_pkg::INVALID_HANDLE, mn, mx);
        send_word(1, 0, 1, 50, 6, 6, mn, mx);
        send_word(1, 0, 50, 32'h8000_0000, 6, 6, mn, mx);
        send_word(1, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, mn, mx);
        // Partly written matrix then full one
        load_elem(32'h8000_0000);
        load_elem(32'h7FFF_FFFF);
        send_word(1, 0, 3, 3, 0, 1, mn, mx);
        load_matrix(0);
        // Loaded matrix: box far away, inverted box, fully inside
        mn = '{32'h0100_0000, 32'h0100_0000, 32'h0100_0000};
        mx = '{32'h0200_0000, 32'h0200_0000, 32'h0200_0000};
        send_word(1, 0, 3, 3, 1, 1, mn, mx);
        send_word(1, 0, 3, 3, 1, 1, mx, mn);
        mn = '{32'hFFFF_8000, 32'hFFFF_8000, 32'h0000_8000};
        mx = '{32'h0000_8000, 32'h0000_8000, 32'h0001_0000};
        send_word(1, 0, 3, 3, 2, 1, mn, mx);
        drain();

        // Random: mostly sane matrices and boxes, some wild
        for (int n = 0; n < 320; n++)
        begin
            if (n == 300)
                calm = 1;
            if (n % 100 == 50)
                load_matrix($urandom_range(0, 3) == 0);
            else if ($urandom_range(0, 19) == 0)
                load_elem(rnd_edge());
            else
                draw_rand($urandom_range(0, 4) == 0);
            if (n == 160)
                drain();
        end
        drain();

        $display("Covered %0d stored, %0d drawn, %0d dropped, %0d culled words.",
                 sb.n_stored, sb.n_drawn, sb.n_dropped, sb.n_culled);
        if (errors == 0 && sb.pending.size() == 0)
            $display("tb_draw_call_frustum_cull_filter passed");
        else
            $display("tb_draw_call_frustum_cull_filter failed");
        $finish;
    end

    // Hard time limit
    initial
    begin : watchdog
        #2000000;
        $display("tb_draw_call_frustum_cull_filter failed");
        $finish;
    end
endmodule

### files.f
src/dccf_pkg.sv
src/dccf_front.sv
src/dccf_fifo.sv
src/dccf_back.sv
src/draw_call_frustum_cull_filter.sv
verif/tb_draw_call_frustum_cull_filter.sv
